// ===== hdl/sha256_stream_hasher_top_macros.svh =====
// Assertion macros for the SHA-256 stream hasher checker.
// Used by the bound checker module only.
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH
// implication checked every clock, off during reset
`define SHS_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication
`define SHS_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== hdl/shs_pkg.sv =====
// Package for the SHA-256 stream hasher: round constants, initial hash,
// front-to-back command type, back-end state type, rotate function. No dependencies.
`timescale 1ns / 1ps
package shs_pkg;
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_OUT
  } bst_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

// ===== hdl/shs_front.sv =====
// Front end: takes input words, drops idle items, queues the rest.
// Depends on shs_pkg.
`timescale 1ns / 1ps
module shs_front
  import shs_pkg::*;
#(
  parameter int Depth = QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_end_of_message,
  input  logic       in_valid,
  output logic       in_ready,
  output item_t      q_item,
  output logic       q_valid,
  input  logic       q_pop
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  item_t            mem_r [Depth];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  logic             push, useful;

  assign in_ready = (cnt_r != (AW+1)'(Depth));
  assign useful = in_byte_present | in_end_of_message;
  // drop idle items at the door
  assign push = in_valid & in_ready & useful;
  assign q_valid = (cnt_r != '0);
  assign q_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{in_data_byte, in_byte_present, in_end_of_message};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end
endmodule

// ===== hdl/shs_back.sv =====
// Back end: block buffer, padding, 64-round compression and digest output.
// Depends on shs_pkg.
`timescale 1ns / 1ps
module shs_back
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  item_t       q_item,
  input  logic        q_valid,
  output logic        q_pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_valid,
  input  logic        out_ready
);
  bst_t st_r, st_nxt;
  logic [31:0] blk_r [16];
  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [5:0]  t_r;
  logic        fin_r;   // compressing the last block of a message
  logic        pad_r;   // padding step: 0 place 0x80, 1 zero/length fill
  logic        eom_r;   // head word's byte is in the block, its message end still pending
  logic [2:0]  oi_r;

  logic [31:0] w, g0, g1, s0, s1, ch, maj, t1, t2, w15, w2;
  logic [3:0]  ti;
  logic [5:0]  fill_inc;
  logic        start_c;

  assign ti = t_r[3:0];
  assign w15 = w_r[ti + 4'd1];
  assign w2 = w_r[ti + 4'd14];
  assign g0 = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
  assign g1 = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
  assign w = (t_r < 6'd16) ? blk_r[ti] : w_r[ti] + g0 + w_r[ti + 4'd9] + g1;
  assign s1 = ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25);
  assign ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1 = v_r[7] + s1 + ch + round_k(t_r) + w;
  assign s0 = ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2 = s0 + maj;
  assign fill_inc = fill_r + 6'd1;

  assign out_valid = (st_r == ST_OUT);
  assign out_digest_word = h_r[oi_r];
  assign out_word_index = oi_r;
  assign out_last_word = (oi_r == 3'd7);

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    start_c = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          // bytes are stored and popped; a message end moves on to padding
          if (q_item.byte_present && fill_r == 6'd63) begin
            start_c = 1'b1;
            st_nxt = ST_ROUND;
            if (!q_item.end_of_message) q_pop = 1'b1;
          end else if (q_item.end_of_message) begin
            st_nxt = ST_PAD;
          end else begin
            q_pop = 1'b1;
          end
        end
      end
      ST_ROUND: if (t_r == 6'd63) st_nxt = ST_FOLD;
      ST_FOLD: begin
        if (fin_r) st_nxt = ST_OUT;
        else if (fill_r == 6'd63 && q_valid && q_item.end_of_message) st_nxt = ST_ROUND;
        else if (eom_r) st_nxt = ST_PAD;
        else st_nxt = ST_IDLE;
      end
      ST_PAD: begin
        if (pad_r) begin
          start_c = 1'b1;
          st_nxt = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (out_ready && oi_r == 3'd7) begin
          st_nxt = ST_IDLE;
          q_pop = 1'b1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      fill_r <= '0;
      bits_r <= '0;
      t_r <= '0;
      fin_r <= 1'b0;
      pad_r <= 1'b0;
      eom_r <= 1'b0;
      oi_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: begin
          if (q_valid && q_item.byte_present) begin
            blk_r[fill_r[5:2]][8*(3-fill_r[1:0]) +: 8] <= q_item.data_byte;
            fill_r <= fill_inc;
            bits_r <= bits_r + 64'd8;
            fin_r <= 1'b0;
          end
          pad_r <= 1'b0;
        end
        ST_ROUND: begin
          w_r[ti] <= w;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          t_r <= t_r + 6'd1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          pad_r <= 1'b0;
          eom_r <= 1'b0;
          oi_r <= '0;
        end
        ST_PAD: begin
          if (!pad_r) begin
            // place 0x80; clear the rest of its word
            for (int j = 0; j < 4; j++) begin
              if (j == fill_r[1:0]) blk_r[fill_r[5:2]][8*(3-j) +: 8] <= 8'h80;
              if (j > fill_r[1:0]) blk_r[fill_r[5:2]][8*(3-j) +: 8] <= 8'h00;
            end
            pad_r <= 1'b1;
          end else begin
            // fill words after the marker; length goes in if it fits
            for (int k = 0; k < 14; k++) begin
              if (4'(k) > fill_r[5:2]) blk_r[k] <= '0;
            end
            if (fill_r < 6'd56) begin
              blk_r[14] <= bits_r[63:32];
              blk_r[15] <= bits_r[31:0];
              fin_r <= 1'b1;
            end else begin
              if (fill_r[5:2] == 4'd14) blk_r[15] <= '0;
              fin_r <= 1'b0;
            end
            // a spilled block leaves an empty block with marker already placed
            fill_r <= (fill_r < 6'd56) ? 6'd0 : 6'd63;
            pad_r <= 1'b0;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            oi_r <= oi_r + 3'd1;
            if (oi_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
              bits_r <= '0;
              fill_r <= '0;
              fin_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
      if (start_c) begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        t_r <= '0;
        if (st_r == ST_IDLE) eom_r <= q_item.end_of_message;
      end
      // second padding block: everything zero but the length
      if (st_r == ST_FOLD && !fin_r && fill_r == 6'd63 && q_valid &&
          q_item.end_of_message) begin
        for (int k = 0; k < 14; k++) blk_r[k] <= '0;
        blk_r[14] <= bits_r[63:32];
        blk_r[15] <= bits_r[31:0];
        fin_r <= 1'b1;
        fill_r <= '0;
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i] + v_r[i];
        t_r <= '0;
      end
    end
  end
endmodule

// ===== hdl/sha256_stream_hasher_top.sv =====
// SHA-256 stream hasher, one byte per item, eight digest words per message.
// Depends on shs_pkg, shs_front and shs_back.
// Bytes are taken at one per cycle while a block fills; each full 64-byte
// block then holds the hashing engine for its 64 rounds on the
// single round unit plus the fold, and input stalls once the queue is full.
// A message end adds the padding steps (marker, then zero/length fill) and
// one or two compressions, then the eight digest words go out one per accepted cycle.
// A queue, two entries deep by default, sits between the input and the hashing engine.
`timescale 1ns / 1ps
module sha256_stream_hasher_top
  import shs_pkg::*;
#(
  parameter int QueueDepth = QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_valid,
  input  logic        out_ready
);
  item_t q_item;
  logic  q_valid, q_pop;

  shs_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .in_data_byte, .in_byte_present, .in_end_of_message,
    .in_valid, .in_ready, .q_item, .q_valid, .q_pop
  );

  shs_back u_back (
    .clk, .rst_n, .q_item, .q_valid, .q_pop,
    .out_digest_word, .out_word_index, .out_last_word, .out_valid, .out_ready
  );
endmodule

// ===== hdl/shs_checker.sv =====
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_stream_hasher_top_macros.svh.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_top_macros.svh"
module shs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_word_index,
  input logic        out_last_word,
  input logic [31:0] out_digest_word
);
  `SHS_ASSERT_IMP(a_last, clk, rst_n, out_valid, out_last_word == (out_word_index == 3'd7))
  `SHS_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_digest_word) && $stable(out_word_index))
  `SHS_ASSERT_NXT(a_seq, clk, rst_n, out_valid && out_ready && !out_last_word,
    out_valid && out_word_index == $past(out_word_index) + 3'd1)
endmodule

bind sha256_stream_hasher_top shs_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_word_index, .out_last_word,
  .out_digest_word
);

// ===== tb/sv/sha256_stream_hasher_top_tb.sv =====
// Self-checking testbench for sha256_stream_hasher_top: byte-stream SHA-256.
// Depends on shs_pkg and the hasher RTL. Digests are predicted by a local
// SHA-256 model and compared word by word against the result channel.
`timescale 1ns / 1ps
module sha256_stream_hasher_top_tb;
  import shs_pkg::*;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_end_of_message;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  logic        out_valid;
  logic        out_ready;

  sha256_stream_hasher_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_data_byte(in_data_byte), .in_byte_present(in_byte_present),
    .in_end_of_message(in_end_of_message), .in_valid(in_valid), .in_ready(in_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word), .out_valid(out_valid), .out_ready(out_ready)
  );

  // predictor state
  logic [31:0] hash_state[8];
  logic [7:0]  msg_block[64];
  int          block_count;
  logic [63:0] msg_bit_len;

  digest_word_t digest_queue[$];
  int  mismatches;
  int  idle_cycles;
  bit  idle_on;        // enables random gaps on both sides
  bit  rx_hold;        // long receiver stall

  localparam int WatchdogLimit = 20000;

  logic [31:0] k_table[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  logic [31:0] iv_table[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_msg_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
           + w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_table[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_digest();
    for (int i = 0; i < 8; i++) hash_state[i] = iv_table[i];
    block_count = 0;
    msg_bit_len = '0;
  endtask

  // advance the predictor by one accepted word
  task automatic predict_digest(logic [7:0] b, logic present, logic eom);
    digest_word_t d;
    if (present) begin
      msg_block[block_count++] = b;
      msg_bit_len += 64'd8;
      if (block_count == 64) begin
        compress_msg_block();
        block_count = 0;
      end
    end
    if (eom) begin
      msg_block[block_count++] = 8'h80;
      if (block_count > 56) begin
        while (block_count < 64) msg_block[block_count++] = 8'h00;
        compress_msg_block();
        block_count = 0;
      end
      while (block_count < 56) msg_block[block_count++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bit_len[63-8*i -: 8];
      compress_msg_block();
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_state[i];
        d.word_index  = i[2:0];
        d.last_word   = (i == 7);
        digest_queue = {digest_queue, d};
      end
      restart_digest();
    end
  endtask

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // receiver: random back-pressure, or a long hold when requested
  always @(negedge clk) begin
    if (rx_hold) out_ready <= 1'b0;
    else if (idle_on) out_ready <= ($urandom_range(99) >= 36);
    else out_ready <= 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    digest_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (digest_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h index %0d", out_digest_word, out_word_index);
      end else begin
        e = digest_queue.pop_front();
        if (out_digest_word !== e.digest_word || out_word_index !== e.word_index ||
            out_last_word !== e.last_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                     e.digest_word, e.word_index, e.last_word,
                     out_digest_word, out_word_index, out_last_word);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(logic [7:0] b, logic present, logic eom);
    if (idle_on)
      while ($urandom_range(99) < 36) @(negedge clk);
    in_data_byte      = b;
    in_byte_present   = present;
    in_end_of_message = eom;
    in_valid          = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_digest(b, present, eom);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_message(int len, bit no_byte_end);
    for (int i = 0; i < len; i++) begin
      // drop in an occasional ignored word
      if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, (i == len - 1) && !no_byte_end);
    end
    if (no_byte_end || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain_digests();
    while (digest_queue.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_empty_and_idle();
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_byte_extremes();
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h55, 1'b1, 1'b0);
    send_word(8'haa, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
  endtask

  // 56 bytes push the length into a second block; 64 end on a full block
  task automatic test_padding_boundary();
    send_message(56, 1'b0);
    send_message(64, 1'b0);
  endtask

  // hold the receiver while whole messages keep arriving
  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        rx_hold = 1'b0;
      end
      begin
        send_message(3, 1'b0);
        send_message(2, 1'b0);
        send_message(1, 1'b0);
      end
    join
    drain_digests();
  endtask

  task automatic test_random_messages();
    int sent;
    sent = 0;
    while (sent < 12) begin
      int len;
      len = $urandom_range(0, 12);
      send_message(len, $urandom_range(3) == 0);
      sent += len + 1;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_byte_present = 1'b0;
    in_end_of_message = 1'b0;
    out_ready = 1'b0;
    idle_on = 1'b0;
    rx_hold = 1'b0;
    mismatches = 0;
    restart_digest();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_and_idle();
    test_byte_extremes();
    test_padding_boundary();
    drain_digests();
    idle_on = 1'b1;
    test_backpressure();
    test_random_messages();
    drain_digests();
    idle_on = 1'b0;
    test_random_messages();
    drain_digests();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && digest_queue.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
